// File: hw/rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg: shared types of the modular exponentiation block
// Command and status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  typedef struct packed {
    logic load;
    logic step;
    logic reduce;
    logic update;
    logic apply;
    logic present;
  } mexp_cmd_t;

  typedef struct packed {
    logic m_zero;
  } mexp_status_t;

endpackage

// File: hw/rtl/mexp_in_if.sv
// ----------------------------------------------------------------------------
// mexp_in_if: request channel
// Valid/ready channel that carries base, exponent and modulus.
// ----------------------------------------------------------------------------
interface mexp_in_if #(
  parameter int OPERAND_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  logic [OPERAND_WIDTH-1:0] base_value;
  logic [OPERAND_WIDTH-1:0] exponent_value;
  logic [OPERAND_WIDTH-1:0] modulus_value;

  modport source (output valid, base_value, exponent_value, modulus_value, input ready);
  modport sink   (input valid, base_value, exponent_value, modulus_value, output ready);
endinterface

// File: hw/rtl/mexp_out_if.sv
// ----------------------------------------------------------------------------
// mexp_out_if: response channel
// Valid/ready channel that carries the power residue.
// ----------------------------------------------------------------------------
interface mexp_out_if #(
  parameter int OPERAND_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  logic [OPERAND_WIDTH-1:0] power_residue;

  modport source (output valid, power_residue, input ready);
  modport sink   (input valid, power_residue, output ready);
endinterface

// File: hw/rtl/mexp_datapath.sv
// ----------------------------------------------------------------------------
// mexp_datapath: operand registers and bit-serial modular multipliers
// Two shift-and-add lanes share one multiplier operand and the modulus, so
// the square and the conditional multiply of one exponent bit run together.
// ----------------------------------------------------------------------------
module mexp_datapath #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                     clk,
  input  mexp_pkg::mexp_cmd_t      cmd,
  output mexp_pkg::mexp_status_t   status,
  input  logic [OPERAND_WIDTH-1:0] base_value,
  input  logic [OPERAND_WIDTH-1:0] exponent_value,
  input  logic [OPERAND_WIDTH-1:0] modulus_value,
  output logic [OPERAND_WIDTH-1:0] power_residue
);

  localparam int W = OPERAND_WIDTH;
  localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

  logic [W-1:0] m;
  logic [W-1:0] y;
  logic [W-1:0] e;
  logic [W-1:0] sq;
  logic [W-1:0] acc;
  logic [W-1:0] tp;
  logic [W-1:0] ta;
  logic [W-1:0] res;
  logic         m_zero;

  logic [W-1:0] x_p;
  logic [W-1:0] tp_dbl;
  logic [W-1:0] ta_dbl;
  logic [W-1:0] tp_next;
  logic [W-1:0] ta_next;

  function automatic logic [W-1:0] add_mod(logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W-1:0] mm);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, mm}) begin
      s = s - {1'b0, mm};
    end
    return s[W-1:0];
  endfunction

  // While the base is reduced, the power lane multiplies the base by one.
  assign x_p     = cmd.reduce ? ONE : sq;
  assign tp_dbl  = add_mod(tp, tp, m);
  assign ta_dbl  = add_mod(ta, ta, m);
  assign tp_next = y[W-1] ? add_mod(tp_dbl, x_p, m) : tp_dbl;
  assign ta_next = y[W-1] ? add_mod(ta_dbl, acc, m) : ta_dbl;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m      <= modulus_value;
      y      <= base_value;
      e      <= exponent_value;
      tp     <= '0;
      ta     <= '0;
      acc    <= (modulus_value == ONE) ? '0 : ONE;
      m_zero <= (modulus_value == '0);
    end else if (cmd.step) begin
      tp <= tp_next;
      ta <= ta_next;
      y  <= {y[W-2:0], 1'b0};
    end else if (cmd.update) begin
      sq <= tp;
      y  <= tp;
      tp <= '0;
      ta <= '0;
      if (cmd.apply) begin
        e <= {1'b0, e[W-1:1]};
        if (e[0]) begin
          acc <= ta;
        end
      end
    end
    if (cmd.present) begin
      res <= m_zero ? '0 : acc;
    end
  end

  assign status.m_zero = m_zero;
  assign power_residue = res;

endmodule

// File: hw/rtl/mexp_controller.sv
// ----------------------------------------------------------------------------
// mexp_controller: sequencer of the modular exponentiation block
// Steps the base reduction and one square-and-multiply round per exponent
// bit, and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module mexp_controller #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  mexp_pkg::mexp_status_t status,
  output mexp_pkg::mexp_cmd_t    cmd
);

  localparam int CW = $clog2(OPERAND_WIDTH);
  localparam logic [CW-1:0] LAST = CW'(OPERAND_WIDTH - 1);

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_REDUCE     = 6'b000010,
    S_REDUCE_UPD = 6'b000100,
    S_MULT       = 6'b001000,
    S_MULT_UPD   = 6'b010000,
    S_FINISH     = 6'b100000
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] bit_cnt;
  logic [CW-1:0] bit_cnt_next;
  logic [CW-1:0] round_cnt;
  logic [CW-1:0] round_cnt_next;
  logic          accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    bit_cnt_next   = bit_cnt;
    round_cnt_next = round_cnt;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load       = 1'b1;
          bit_cnt_next   = '0;
          round_cnt_next = '0;
          state_next     = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (status.m_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.step     = 1'b1;
          cmd.reduce   = 1'b1;
          bit_cnt_next = bit_cnt + 1'b1;
          if (bit_cnt == LAST) begin
            bit_cnt_next = '0;
            state_next   = S_REDUCE_UPD;
          end
        end
      end
      S_REDUCE_UPD: begin
        cmd.update = 1'b1;
        state_next = S_MULT;
      end
      S_MULT: begin
        cmd.step     = 1'b1;
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == LAST) begin
          bit_cnt_next = '0;
          state_next   = S_MULT_UPD;
        end
      end
      S_MULT_UPD: begin
        cmd.update     = 1'b1;
        cmd.apply      = 1'b1;
        round_cnt_next = round_cnt + 1'b1;
        state_next     = (round_cnt == LAST) ? S_FINISH : S_MULT;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.present = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bit_cnt   <= '0;
      round_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      bit_cnt   <= bit_cnt_next;
      round_cnt <= round_cnt_next;
      if (cmd.present) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_present_free: assert property (@(posedge clk) disable iff (rst)
    cmd.present |-> (!out_valid || out_ready))
    else $error("result register overwritten while a beat is pending");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_REDUCE))
    else $error("accepted beat did not start the base reduction");

  a_last_round: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULT_UPD && round_cnt == LAST) |=> (state == S_FINISH))
    else $error("exponent rounds did not end after the last bit");

endmodule

// File: hw/rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation: base ^ exponent mod modulus
// Right-to-left square and multiply with exact bit-serial modular products.
// ----------------------------------------------------------------------------
// One beat is worked on at a time. After a request beat is accepted the base
// is reduced, then every exponent bit takes a round in which two shift-and-add
// lanes form the square and the conditional product in parallel, one
// multiplier bit per cycle. The result is registered once the response
// register is free, and the next request is taken in the following cycle,
// even while the previous result still waits on the response channel. A zero
// modulus skips the rounds and answers 0.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 32
) (
  input logic    clk,
  input logic    rst,
  mexp_in_if.sink    req,
  mexp_out_if.source rsp
);

  mexp_pkg::mexp_cmd_t    cmd;
  mexp_pkg::mexp_status_t status;

  mexp_controller #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .status   (status),
    .cmd      (cmd)
  );

  mexp_datapath #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .base_value    (req.base_value),
    .exponent_value(req.exponent_value),
    .modulus_value (req.modulus_value),
    .power_residue (rsp.power_residue)
  );

endmodule
